@@ sv/text_console_writer_assert.svh @@
// assertion macros used by the checker in tcw_checker.sv
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// same-cycle implication, off during reset
`define TCW_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define TCW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/tcw_pkg.sv @@
`default_nettype none
package tcw_pkg;

  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  localparam int CHAR_W   = 8;
  localparam int ATTR_W   = 8;
  localparam int POS_W    = 8;
  localparam int CELL_W   = CHAR_W + ATTR_W;
  localparam int CURSOR_W = 11;
  localparam int CFG_IDX_W = 8;

  localparam int S_DATA_W = 40;
  localparam int M_DATA_W = 32;

  localparam logic [ATTR_W-1:0] DEFAULT_ATTR_RST = 8'd15;
  localparam logic [ATTR_W-1:0] ERROR_ATTR_RST   = 8'd244;

  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0a;
  localparam logic [CHAR_W-1:0] ERROR_CHAR   = 8'h45;
  localparam logic [CHAR_W-1:0] SPACE_CHAR   = 8'h20;

  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_ATTR = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ERROR_ATTR   = 8'd1;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_BACK  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_ADDR,
    ST_EXEC,
    ST_RDATA,
    ST_SCROLL,
    ST_ZERO,
    ST_FILL,
    ST_CUR,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

@@ sv/tcw_ram.sv @@
`default_nettype none
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ sv/text_console_writer.sv @@
`default_nettype none
// channel  dir  bits   contents
// s_*      in   40+2   tdata: char_code, attr_in, use_cursor, row_in, col_in; tuser: operation
// m_*      out  32     tdata: cursor_cell, cell_char, cell_attr, out_of_range
// cfg_*    in   8+8    register index, write data
//
// after reset the screen memory is zeroed, one cell a cycle
// a put, backspace or read passes through address multiply, ram access, cursor multiply or
// read data and output load; an off-screen put skips the cursor multiply, an off-screen
// read goes straight to the output load; a put past the last row adds a scroll that moves
// every row up and zeroes the last; a clear fills all cells with spaces (single ram port pair)
// s_tready is low while a transaction is in work; a stalled result holds the block in its
// last step
module text_console_writer #(
  parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // char_code[7:0], attr_in[15:8], use_cursor[16], row_in[24:17], col_in[32:25]
  input  wire logic [tcw_pkg::S_DATA_W-1:0]   s_tdata,
  // operation[1:0]
  input  wire logic [1:0]                     s_tuser,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // cursor_cell[10:0], cell_char[18:11], cell_attr[26:19], out_of_range[27]
  output logic      [tcw_pkg::M_DATA_W-1:0]   m_tdata,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tcw_pkg::ATTR_W-1:0]     cfg_data
);

  import tcw_pkg::*;

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS);
  localparam int CLW   = $clog2(COLUMNS);

  localparam logic [AW-1:0]  LAST_CELL  = AW'(CELLS - 1);
  localparam logic [AW-1:0]  SCROLL_END = AW'(CELLS - COLUMNS);
  localparam logic [AW-1:0]  COL_STEP   = AW'(COLUMNS);
  localparam logic [RW-1:0]  LAST_ROW   = RW'(ROWS - 1);
  localparam logic [CLW-1:0] LAST_COL   = CLW'(COLUMNS - 1);
  localparam logic [POS_W:0] ROW_LIM    = (POS_W + 1)'(ROWS);
  localparam logic [POS_W:0] COL_LIM    = (POS_W + 1)'(COLUMNS);

  state_t state, state_next;

  logic [ATTR_W-1:0] default_attr, error_attr;

  logic [CHAR_W-1:0] char_code;
  logic [ATTR_W-1:0] attr_in;
  logic              use_cursor;
  logic [POS_W-1:0]  row_in, col_in;
  op_t               operation;
  logic              off_screen;
  logic              put_err;
  logic [CELL_W-1:0] put_cell;

  op_t               op_q;
  logic              nl_q, err_q;
  logic [CELL_W-1:0] wcell;
  logic [RW-1:0]     wrow, crow;
  logic [CLW-1:0]    wcol, ccol;
  logic [AW-1:0]     addr, cursor, cnt;

  logic [CHAR_W-1:0] res_char;
  logic [ATTR_W-1:0] res_attr;
  logic              res_flag;

  logic [RW-1:0]     mul_r;
  logic [CLW-1:0]    mul_c;
  logic [AW-1:0]     mul_out;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;

  logic                    out_load;
  logic [AW+CURSOR_W-1:0]  cursor_ext;
  logic                    adv_row;

  assign char_code  = s_tdata[7:0];
  assign attr_in    = s_tdata[15:8];
  assign use_cursor = s_tdata[16];
  assign row_in     = s_tdata[24:17];
  assign col_in     = s_tdata[32:25];
  assign operation  = op_t'(s_tuser);
  assign off_screen = ({1'b0, row_in} >= ROW_LIM) || ({1'b0, col_in} >= COL_LIM);
  assign put_err    = (operation == OP_PUT) && !use_cursor && off_screen;
  assign put_cell   = {(attr_in == '0) ? default_attr : attr_in, char_code};

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  // shared row*COLUMNS+col unit
  assign mul_r   = (state == ST_CUR) ? crow : wrow;
  assign mul_c   = (state == ST_CUR) ? ccol : wcol;
  assign mul_out = AW'(mul_r) * COL_STEP + AW'(mul_c);

  assign adv_row    = nl_q || (wcol == LAST_COL);
  assign out_load   = (state == ST_DONE) && (!m_tvalid || m_tready);
  assign cursor_ext = {{CURSOR_W{1'b0}}, cursor};

  tcw_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_waddr  = addr;
    ram_wdata  = wcell;
    ram_raddr  = addr;
    case (state)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = cnt;
        ram_wdata = '0;
        if (cnt == LAST_CELL) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_tvalid) begin
          if (operation == OP_CLEAR) begin
            state_next = ST_FILL;
          end else if (operation == OP_READ && off_screen) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_ADDR;
          end
        end
      end
      ST_ADDR: state_next = ST_EXEC;
      ST_EXEC: begin
        case (op_q)
          OP_PUT: begin
            ram_we = !nl_q;
            if (err_q) begin
              state_next = ST_DONE;
            end else if (adv_row && wrow == LAST_ROW) begin
              state_next = ST_SCROLL;
            end else begin
              state_next = ST_CUR;
            end
          end
          OP_BACK: begin
            ram_we     = 1'b1;
            state_next = ST_CUR;
          end
          OP_READ: begin
            ram_re     = 1'b1;
            state_next = ST_RDATA;
          end
          default: state_next = ST_DONE;
        endcase
      end
      ST_RDATA: state_next = ST_DONE;
      ST_SCROLL: begin
        ram_re    = (cnt != SCROLL_END);
        ram_raddr = cnt + COL_STEP;
        ram_we    = (cnt != '0);
        ram_waddr = cnt - AW'(1);
        ram_wdata = ram_rdata;
        if (cnt == SCROLL_END) state_next = ST_ZERO;
      end
      ST_ZERO: begin
        ram_we    = 1'b1;
        ram_waddr = cnt;
        ram_wdata = '0;
        if (cnt == LAST_CELL) state_next = ST_CUR;
      end
      ST_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = cnt;
        ram_wdata = {default_attr, SPACE_CHAR};
        if (cnt == LAST_CELL) state_next = ST_CUR;
      end
      ST_CUR: state_next = ST_DONE;
      ST_DONE: begin
        if (!m_tvalid || m_tready) state_next = ST_IDLE;
      end
      default: state_next = ST_INIT;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      default_attr <= DEFAULT_ATTR_RST;
      error_attr   <= ERROR_ATTR_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_DEFAULT_ATTR) default_attr <= cfg_data;
      if (cfg_index == CFG_ERROR_ATTR)   error_attr   <= cfg_data;
    end
  end

  // control and cursor
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      crow     <= '0;
      ccol     <= '0;
      cursor   <= '0;
      m_tvalid <= 1'b0;
    end else begin
      case (state)
        ST_INIT, ST_ZERO, ST_FILL: begin
          if (cnt != LAST_CELL) cnt <= cnt + AW'(1);
        end
        ST_SCROLL: begin
          if (cnt != SCROLL_END) cnt <= cnt + AW'(1);
        end
        ST_IDLE: cnt <= '0;
        default: ;
      endcase
      if (state == ST_FILL && cnt == LAST_CELL) begin
        crow <= '0;
        ccol <= '0;
      end
      if (state == ST_EXEC) begin
        if (op_q == OP_BACK) begin
          crow <= wrow;
          ccol <= wcol;
        end else if (op_q == OP_PUT && !err_q) begin
          if (adv_row) begin
            ccol <= '0;
            crow <= (wrow == LAST_ROW) ? wrow : wrow + RW'(1);
          end else begin
            crow <= wrow;
            ccol <= wcol + CLW'(1);
          end
        end
      end
      if (state == ST_CUR) cursor <= mul_out;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // transaction datapath
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op_q     <= operation;
      res_char <= '0;
      res_attr <= '0;
      err_q    <= put_err;
      nl_q     <= !put_err && (char_code == NEWLINE_CHAR);
      res_flag <= put_err || ((operation == OP_READ) && off_screen);
      case (operation)
        OP_PUT: begin
          if (put_err) begin
            wcell <= {error_attr, ERROR_CHAR};
            wrow  <= LAST_ROW;
            wcol  <= LAST_COL;
          end else if (use_cursor) begin
            wcell <= put_cell;
            wrow  <= crow;
            wcol  <= ccol;
          end else begin
            wcell <= put_cell;
            wrow  <= row_in[RW-1:0];
            wcol  <= col_in[CLW-1:0];
          end
        end
        OP_BACK: begin
          wcell <= {default_attr, SPACE_CHAR};
          if (ccol != '0) begin
            wrow <= crow;
            wcol <= ccol - CLW'(1);
          end else if (crow != '0) begin
            wrow <= crow - RW'(1);
            wcol <= LAST_COL;
          end else begin
            wrow <= '0;
            wcol <= '0;
          end
        end
        default: begin
          wcell <= put_cell;
          wrow  <= row_in[RW-1:0];
          wcol  <= col_in[CLW-1:0];
        end
      endcase
    end
    if (state == ST_ADDR) addr <= mul_out;
    if (state == ST_RDATA) begin
      res_char <= ram_rdata[CHAR_W-1:0];
      res_attr <= ram_rdata[CELL_W-1:CHAR_W];
    end
    if (out_load) begin
      m_tdata <= {(M_DATA_W - CURSOR_W - CHAR_W - ATTR_W - 1)'(0), res_flag, res_attr,
                  res_char, cursor_ext[CURSOR_W-1:0]};
    end
  end

endmodule
`default_nettype wire

@@ sv/tcw_checker.sv @@
`default_nettype none
`include "text_console_writer_assert.svh"
module tcw_checker #(
  parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         s_tvalid,
  input wire logic                         s_tready,
  input wire logic                         m_tvalid,
  input wire logic                         m_tready,
  input wire logic [tcw_pkg::M_DATA_W-1:0] m_tdata
);

  import tcw_pkg::*;

  localparam logic [31:0] CELL_LIM = 32'(ROWS * COLUMNS);

  // held result stays put
  `TCW_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

  // one transaction in work at a time
  `TCW_ASSERT_NEXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready, "accepted a second transaction while busy")

  // cursor stays on the screen
  `TCW_ASSERT_NOW(a_cursor_range, clk, rst, m_tvalid, {21'd0, m_tdata[10:0]} < CELL_LIM, "cursor beyond last cell")

  // an off-screen position never returns cell contents
  `TCW_ASSERT_NOW(a_off_screen_zero, clk, rst, m_tvalid && m_tdata[27], m_tdata[26:11] == 16'd0, "cell data with out of range flag")

endmodule

bind text_console_writer tcw_checker #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_tcw_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);
`default_nettype wire

@@ bench/console_checker.sv @@
`default_nettype none
module console_checker #(
  parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  input  wire logic                           s_tready,
  // char_code, attr_in, use_cursor, row_in, col_in
  input  wire logic [tcw_pkg::S_DATA_W-1:0]   s_tdata,
  // operation
  input  wire logic [1:0]                     s_tuser,
  input  wire logic                           m_tvalid,
  input  wire logic                           m_tready,
  // cursor_cell, cell_char, cell_attr, out_of_range
  input  wire logic [tcw_pkg::M_DATA_W-1:0]   m_tdata,
  input  wire logic                           cfg_valid,
  input  wire logic                           cfg_ready,
  input  wire logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tcw_pkg::ATTR_W-1:0]     cfg_data,
  output int                                  errors,
  output int                                  pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import tcw_pkg::*;

  localparam int CELLS = ROWS * COLUMNS;

  typedef struct packed {
    logic       oor;
    logic [7:0] attr;
    logic [7:0] ch;
    logic [10:0] cursor;
  } console_result_t;

  logic [CELL_W-1:0] screen [CELLS];
  int unsigned       cursor;
  logic [ATTR_W-1:0] dflt_attr;
  logic [ATTR_W-1:0] err_attr;
  console_result_t   results_due [$];
  int                n_err = 0;
  int                n_results = 0;

  task automatic apply_console_op(input op_t op, input logic [7:0] ch, input logic [7:0] attr,
                                  input logic at_cur, input logic [7:0] row,
                                  input logic [7:0] col, output console_result_t r);
    int unsigned pos;
    logic [7:0]  a;
    logic        off;
    off = (row >= ROWS) || (col >= COLUMNS);
    a = (attr == 8'd0) ? dflt_attr : attr;
    r = '0;
    case (op)
      OP_PUT: begin
        if (!at_cur && off) begin
          screen[CELLS-1] = {err_attr, ERROR_CHAR};
          r.oor = 1'b1;
        end else begin
          pos = at_cur ? cursor : row * COLUMNS + col;
          if (pos >= CELLS) pos = CELLS - 1;
          if (ch == NEWLINE_CHAR) begin
            pos = (pos / COLUMNS + 1) * COLUMNS;
          end else begin
            screen[pos] = {a, ch};
            pos++;
          end
          // scroll up one row, last row zeroed
          if (pos >= CELLS) begin
            for (int i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
            for (int i = CELLS - COLUMNS; i < CELLS; i++) screen[i] = '0;
            pos -= COLUMNS;
          end
          cursor = pos;
        end
      end
      OP_BACK: begin
        pos = cursor;
        if (pos >= CELLS) pos = CELLS - 1;
        if (pos > 0) pos--;
        screen[pos] = {dflt_attr, SPACE_CHAR};
        cursor = pos;
      end
      OP_CLEAR: begin
        for (int i = 0; i < CELLS; i++) screen[i] = {dflt_attr, SPACE_CHAR};
        cursor = 0;
      end
      default: begin
        if (off) begin
          r.oor = 1'b1;
        end else begin
          {r.attr, r.ch} = screen[row * COLUMNS + col];
        end
      end
    endcase
    r.cursor = cursor[10:0];
  endtask

  always @(posedge clk) begin
    console_result_t got;
    console_result_t want;
    if (rst) begin
      for (int i = 0; i < CELLS; i++) screen[i] = '0;
      cursor = 0;
      dflt_attr = DEFAULT_ATTR_RST;
      err_attr = ERROR_ATTR_RST;
      results_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_DEFAULT_ATTR) dflt_attr = cfg_data;
        else if (cfg_index == CFG_ERROR_ATTR) err_attr = cfg_data;
      end
      if (s_tvalid && s_tready) begin
        apply_console_op(op_t'(s_tuser), s_tdata[7:0], s_tdata[15:8], s_tdata[16],
                         s_tdata[24:17], s_tdata[32:25], want);
        results_due.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata[27:0];
        n_results++;
        if (results_due.size() == 0) begin
          n_err++;
          if (n_err <= 10)
            $display("console_checker: result %0d with no transaction waiting: %h",
                     n_results, m_tdata);
        end else begin
          want = results_due.pop_front();
          if (got !== want) begin
            n_err++;
            if (n_err <= 10)
              $display({"console_checker: result %0d expected cursor %0d char %h attr %h ",
                        "oor %b, got cursor %0d char %h attr %h oor %b"},
                       n_results, want.cursor, want.ch, want.attr, want.oor,
                       got.cursor, got.ch, got.attr, got.oor);
          end
        end
      end
    end
    errors <= n_err;
    pending <= results_due.size();
  end
endmodule
`default_nettype wire

@@ bench/tb_top.sv @@
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tcw_pkg::*;

  localparam int COLS  = DEF_COLUMNS;
  localparam int NROWS = DEF_ROWS;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  // char_code, attr_in, use_cursor, row_in, col_in
  logic [S_DATA_W-1:0]   s_tdata = '0;
  // operation
  logic [1:0]            s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // cursor_cell, cell_char, cell_attr, out_of_range
  logic [M_DATA_W-1:0]   m_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [ATTR_W-1:0]     cfg_data = '0;
  int                    errors;
  int                    pending;
  bit                    quiet = 1'b0;

  text_console_writer #(.COLUMNS(COLS), .ROWS(NROWS)) uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  console_checker #(.COLUMNS(COLS), .ROWS(NROWS)) u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("tb_top: errors");
    $finish;
  end

  // result side stalls
  initial begin
    forever begin
      if (quiet) begin
        m_tready <= 1'b1;
        @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 200 : 30)) @(posedge clk);
        if (!quiet) begin
          m_tready <= 1'b0;
          repeat ($urandom_range(1, 18)) @(posedge clk);
        end
      end
    end
  end

  task automatic send_cmd(input op_t op, input logic [7:0] ch, input logic [7:0] attr,
                          input logic at_cur, input logic [7:0] row, input logic [7:0] col);
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {7'd0, col, row, at_cur, attr, ch};
    do @(posedge clk); while (!s_tready);
    if (!quiet && $urandom_range(0, 6) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic configure(input logic [7:0] dflt, input logic [7:0] err);
    logic [7:0] idx [3];
    logic [7:0] val [3];
    idx = '{CFG_ERROR_ATTR, 8'($urandom_range(2, 255)), CFG_DEFAULT_ATTR};
    val = '{err, 8'($urandom_range(0, 255)), dflt};
    wait_idle();
    foreach (idx[i]) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_row();
    return ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                       : 8'($urandom_range(0, NROWS - 1));
  endfunction

  function automatic logic [7:0] pick_col();
    return ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                       : 8'($urandom_range(0, COLS - 1));
  endfunction

  task automatic random_phase(input int count);
    int         r;
    int         typing;
    logic [7:0] ch;
    logic [7:0] attr;
    typing = 0;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      ch = ($urandom_range(0, 9) == 0) ? NEWLINE_CHAR : 8'($urandom_range(0, 255));
      attr = ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
      if (typing == 0 && $urandom_range(0, 40) == 0) typing = $urandom_range(10, 90);
      if (typing > 0) begin
        typing--;
        send_cmd(OP_PUT, 8'($urandom_range(32, 126)), attr, 1'b1,
                 8'($urandom), 8'($urandom));
      end else if (r < 40) begin
        send_cmd(OP_PUT, ch, attr, 1'b1, 8'($urandom), 8'($urandom));
      end else if (r < 62) begin
        send_cmd(OP_PUT, ch, attr, 1'b0, pick_row(), pick_col());
      end else if (r < 70) begin
        send_cmd(OP_BACK, 8'($urandom), 8'($urandom), 1'($urandom), 8'($urandom),
                 8'($urandom));
      end else if (r < 99) begin
        send_cmd(OP_READ, 8'($urandom), 8'($urandom), 1'($urandom), pick_row(), pick_col());
      end else begin
        send_cmd(OP_CLEAR, 8'($urandom), 8'($urandom), 1'($urandom), 8'($urandom),
                 8'($urandom));
      end
      if ($urandom_range(0, 149) == 0) wait_idle();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part with reset attributes
    send_cmd(OP_READ, 8'h00, 8'h00, 1'b0, 8'd0, 8'd0);
    send_cmd(OP_PUT, "A", 8'h00, 1'b1, 8'd0, 8'd0);
    send_cmd(OP_PUT, 8'hff, 8'hff, 1'b1, 8'd0, 8'd0);
    send_cmd(OP_PUT, 8'h00, 8'h01, 1'b1, 8'd0, 8'd0);
    send_cmd(OP_READ, 8'h00, 8'h00, 1'b0, 8'd0, 8'd1);
    send_cmd(OP_PUT, "Z", 8'h00, 1'b1, 8'd255, 8'd255);
    send_cmd(OP_PUT, "x", 8'h00, 1'b0, 8'd24, 8'd79);
    send_cmd(OP_READ, 8'h00, 8'h00, 1'b0, 8'd24, 8'd0);
    send_cmd(OP_PUT, "q", 8'h33, 1'b0, 8'd25, 8'd0);
    send_cmd(OP_PUT, "q", 8'h33, 1'b0, 8'd0, 8'd80);
    send_cmd(OP_PUT, "q", 8'h33, 1'b0, 8'd255, 8'd255);
    send_cmd(OP_READ, 8'h00, 8'h00, 1'b0, 8'd24, 8'd79);
    send_cmd(OP_READ, 8'h00, 8'h00, 1'b0, 8'd25, 8'd0);
    send_cmd(OP_READ, 8'hff, 8'hff, 1'b1, 8'd0, 8'd255);
    send_cmd(OP_PUT, NEWLINE_CHAR, 8'h00, 1'b1, 8'd0, 8'd0);
    send_cmd(OP_PUT, NEWLINE_CHAR, 8'h00, 1'b0, 8'd24, 8'd5);
    send_cmd(OP_PUT, NEWLINE_CHAR, 8'h00, 1'b0, 8'd3, 8'd79);
    send_cmd(OP_BACK, 8'h00, 8'h00, 1'b0, 8'd0, 8'd0);
    send_cmd(OP_CLEAR, 8'h00, 8'h00, 1'b0, 8'd0, 8'd0);
    send_cmd(OP_BACK, 8'hff, 8'hff, 1'b1, 8'd255, 8'd255);
    send_cmd(OP_READ, 8'h00, 8'h00, 1'b0, 8'd0, 8'd0);
    send_cmd(OP_PUT, "k", 8'h80, 1'b0, 8'd24, 8'd78);
    send_cmd(OP_PUT, "l", 8'h00, 1'b1, 8'd0, 8'd0);
    send_cmd(OP_PUT, "m", 8'h00, 1'b1, 8'd0, 8'd0);
    send_cmd(OP_READ, 8'h00, 8'h00, 1'b0, 8'd23, 8'd79);

    configure(8'd0, 8'd255);
    send_cmd(OP_PUT, "n", 8'h00, 1'b1, 8'd0, 8'd0);
    send_cmd(OP_PUT, "o", 8'h00, 1'b0, 8'd200, 8'd3);
    random_phase(220);
    configure(8'd255, 8'd0);
    random_phase(220);
    configure(8'($urandom), 8'($urandom));
    random_phase(220);
    configure(8'd7, 8'd200);
    random_phase(220);
    configure(8'($urandom), 8'($urandom));
    random_phase(220);
    configure(DEFAULT_ATTR_RST, ERROR_ATTR_RST);
    quiet = 1'b1;
    random_phase(220);

    wait_idle();
    repeat (10) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end
endmodule
`default_nettype wire
